// ===== sv/dta_pkg.sv =====
// Shared widths, constants and the arctangent table of the torsion angle pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package dta_pkg;

  localparam int unsigned COORD_FRAC_BITS_DEF = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 8;

  localparam int unsigned CW = 32;          // coordinate
  localparam int unsigned NPT = 12;         // coordinates per input word
  localparam int unsigned DW = CW + 1;      // bond vector component
  localparam int unsigned NW = 2 * DW + 1;  // normal component
  localparam int unsigned SW = 2 * NW + 1;  // dot products, triple cross term
  localparam int unsigned BW = 2 * SW;      // product of squared normal lengths
  localparam int unsigned TW = DW + SW + 2; // triple product

  localparam int unsigned IN_TDATA_W  = NPT * CW;
  localparam int unsigned ANGLE_W     = 17;
  localparam int unsigned OUT_TDATA_W = ((ANGLE_W + 7) / 8) * 8;

  localparam int unsigned MUL_LAT = 4;
  localparam int unsigned RAD_W   = 60;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned XW      = 32;

  localparam int unsigned CORDIC_STEPS = 31;
  localparam int unsigned ANG_W        = 32;
  localparam int unsigned DPR_W        = 30;
  localparam logic [ANG_W-1:0] PI_Q30      = 32'd3373259426;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [DPR_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;
  localparam int unsigned INV_THRESHOLD = 1000000;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

endpackage

`default_nettype wire

// ===== sv/dta_mul.sv =====
// Pipelined signed multiplier built from 32x32 partial products.
// Depends on dta_pkg.
`default_nettype none

module dta_mul #(
  parameter int unsigned WA = 33,
  parameter int unsigned WB = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import dta_pkg::*;

  localparam int unsigned PW = WA + WB;
  localparam int unsigned NA = (WA + 31) / 32;
  localparam int unsigned NB = (WB + 31) / 32;

  logic [WA-1:0]        aa;
  logic [WB-1:0]        bb;
  logic [NA*32-1:0]     ma_d, ma_q;
  logic [NB*32-1:0]     mb_d, mb_q;
  logic [2:0]           neg_q;
  logic [63:0]          pp_d [NA][NB];
  logic [63:0]          pp_q [NA][NB];
  logic [PW-1:0]        row_d [NA];
  logic [PW-1:0]        row_q [NA];
  logic [PW-1:0]        sum_d;
  logic signed [PW-1:0] p_d, p_q;

  // magnitudes
  always_comb begin
    aa   = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
    bb   = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);
    ma_d = (NA*32)'(aa);
    mb_d = (NB*32)'(bb);
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_d[i][j] = ma_q[32*i +: 32] * mb_q[32*j +: 32];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (row_q[i] << (32 * i));
    end
    p_d = neg_q[2] ? -$signed(sum_d) : $signed(sum_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      neg_q <= {neg_q[1:0], a_i[WA-1] ^ b_i[WB-1]};
      pp_q  <= pp_d;
      row_q <= row_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== sv/dta_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, W/2 stages.
// Depends on dta_pkg.
`default_nettype none

module dta_isqrt #(
  parameter int unsigned W = dta_pkg::RAD_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     rad_i,
  output logic [W/2-1:0]   root_o
);
  import dta_pkg::*;

  localparam int unsigned S = W / 2;

  logic [W:0] v_w [S+1];
  logic [W:0] r_w [S+1];
  logic [W:0] v_q [S];
  logic [W:0] r_q [S];

  assign v_w[0] = {1'b0, rad_i};
  assign r_w[0] = '0;

  for (genvar s = 0; s < S; s++) begin : g_stage
    localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2 * s);
    logic [W:0] trial, v_d, r_d;

    always_comb begin
      trial = r_w[s] + BIT;
      if (v_w[s] >= trial) begin
        v_d = v_w[s] - trial;
        r_d = (r_w[s] >> 1) + BIT;
      end else begin
        v_d = v_w[s];
        r_d = r_w[s] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s] <= v_d;
        r_q[s] <= r_d;
      end
    end

    assign v_w[s+1] = v_q[s];
    assign r_w[s+1] = r_q[s];
  end

  assign root_o = r_w[S][W/2-1:0];

endmodule

`default_nettype wire

// ===== sv/dta_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (x, y) in Q30 radians, clamped to [0, pi].
// Depends on dta_pkg (arctangent table, widths).
`default_nettype none

module dta_cordic (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [dta_pkg::XW-1:0] x_i,
  input  logic [dta_pkg::ROOT_W-1:0]   y_i,
  output logic [dta_pkg::ANG_W-1:0]    ang_o
);
  import dta_pkg::*;

  localparam int unsigned CXW = XW + 3;
  localparam int unsigned AW  = ANG_W + 2;

  function automatic logic signed [CXW-1:0] shr0(input logic signed [CXW-1:0] v,
                                                 input int unsigned sh);
    logic signed [CXW-1:0] r;
    if (v[CXW-1]) r = -((-v) >>> sh);
    else          r = v >>> sh;
    return r;
  endfunction

  logic signed [CXW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CXW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [AW-1:0]  a_q [CORDIC_STEPS+1];
  logic signed [CXW-1:0] x0, y0, xs0, ys0;
  logic signed [AW-1:0]  a0;

  // turn a left-half vector by -90 degrees first
  always_comb begin
    xs0 = CXW'(x_i);
    ys0 = CXW'(y_i);
    if (x_i[XW-1]) begin
      x0 = ys0;
      y0 = -xs0;
      a0 = AW'(HALF_PI_Q30);
    end else begin
      x0 = xs0;
      y0 = ys0;
      a0 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      a_q[0] <= a0;
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
    logic signed [CXW-1:0] xn, yn;
    logic signed [AW-1:0]  an;

    always_comb begin
      if (!y_q[s][CXW-1]) begin
        xn = x_q[s] + shr0(y_q[s], s);
        yn = y_q[s] - shr0(x_q[s], s);
        an = a_q[s] + AW'(ATAN_Q30[s]);
      end else begin
        xn = x_q[s] - shr0(y_q[s], s);
        yn = y_q[s] + shr0(x_q[s], s);
        an = a_q[s] - AW'(ATAN_Q30[s]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s+1] <= xn;
        y_q[s+1] <= yn;
        a_q[s+1] <= an;
      end
    end
  end

  always_comb begin
    if (a_q[CORDIC_STEPS][AW-1]) begin
      ang_o = '0;
    end else if (a_q[CORDIC_STEPS] > $signed({2'b00, PI_Q30})) begin
      ang_o = PI_Q30;
    end else begin
      ang_o = a_q[CORDIC_STEPS][ANG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/dihedral_torsion_angle.sv =====
// Top level: dihedral angle of four points, fully pipelined, one word per cycle while not stalled.
// Depends on dta_pkg, dta_mul, dta_isqrt, dta_cordic.
//
//  port group   dir  tdata bits (low first)                  tuser
//  s_axis       in   p1_x p1_y p1_z p2_x .. p4_z, 32b each   -
//  m_axis       out  torsion_angle 17b, zero filled to 24b   degenerate
//
// A new word enters every cycle while the pipeline is not stalled. The depth is
// set by three 4-stage wide multiply levels, the 30-stage square root and the
// 32-stage CORDIC.
// Reset clears only valid bits. A stall holds every stage only when the last
// stage and the output register are both full; bubbles keep draining otherwise.
`default_nettype none

module dihedral_torsion_angle #(
  parameter int unsigned COORD_FRAC_BITS = dta_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = dta_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z
  input  logic [dta_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // torsion_angle, then zero fill
  output logic [dta_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // degenerate
  output logic                              m_axis_tuser_o
);
  import dta_pkg::*;

  localparam int unsigned F_IDX  = 3 * MUL_LAT + 4;
  localparam int unsigned NST    = F_IDX + 4 + ROOT_W + CORDIC_STEPS + 1 + 1;
  localparam int unsigned KJ_DLY = 2 * MUL_LAT + 2;
  localparam int unsigned C_DLY  = MUL_LAT;
  localparam int unsigned DN_DLY = NST - 1 - F_IDX;
  localparam int unsigned DG_DLY = NST - 2 - F_IDX;
  localparam int unsigned X_DLY  = ROOT_W;
  localparam int unsigned NCH    = (BW + 31) / 32;
  localparam int unsigned BLW    = $clog2(BW + 1);
  localparam int unsigned KW     = $clog2((BW - RAD_W + 1) / 2 + 1);
  localparam int unsigned PRW    = ANG_W + DPR_W;
  localparam logic [BW-1:0] DEG_LIM =
    ((BW'(1) << (8 * COORD_FRAC_BITS)) + BW'(INV_THRESHOLD - 1)) / BW'(INV_THRESHOLD);

  logic en;
  logic [NST-1:0] vld_q;
  logic out_vld_q;
  logic [ANGLE_W-1:0] ang_q, ang_d;
  logic degen_out_q;

  // ---------------- input and bond vectors
  logic signed [CW-1:0] pt_q [NPT];
  logic signed [DW-1:0] ij_q [3];
  logic signed [DW-1:0] kj_q [3];
  logic signed [DW-1:0] kl_q [3];

  assign en = !(vld_q[NST-1] && out_vld_q && !m_axis_tready_i);
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NPT; i++) pt_q[i] <= s_axis_tdata_i[CW*i +: CW];
      for (int i = 0; i < 3; i++) begin
        ij_q[i] <= DW'(pt_q[i])     - DW'(pt_q[3+i]);
        kj_q[i] <= DW'(pt_q[6+i])   - DW'(pt_q[3+i]);
        kl_q[i] <= DW'(pt_q[6+i])   - DW'(pt_q[9+i]);
      end
    end
  end

  // ---------------- normals d = ij x kj, g = kl x kj
  logic signed [DW-1:0]   ma_a [12];
  logic signed [DW-1:0]   ma_b [12];
  logic signed [2*DW-1:0] ma_p [12];
  logic signed [NW-1:0]   d_q [3];
  logic signed [NW-1:0]   g_q [3];

  always_comb begin
    ma_a[0]  = ij_q[1]; ma_b[0]  = kj_q[2];
    ma_a[1]  = ij_q[2]; ma_b[1]  = kj_q[1];
    ma_a[2]  = ij_q[2]; ma_b[2]  = kj_q[0];
    ma_a[3]  = ij_q[0]; ma_b[3]  = kj_q[2];
    ma_a[4]  = ij_q[0]; ma_b[4]  = kj_q[1];
    ma_a[5]  = ij_q[1]; ma_b[5]  = kj_q[0];
    ma_a[6]  = kj_q[2]; ma_b[6]  = kl_q[1];
    ma_a[7]  = kj_q[1]; ma_b[7]  = kl_q[2];
    ma_a[8]  = kj_q[0]; ma_b[8]  = kl_q[2];
    ma_a[9]  = kj_q[2]; ma_b[9]  = kl_q[0];
    ma_a[10] = kj_q[1]; ma_b[10] = kl_q[0];
    ma_a[11] = kj_q[0]; ma_b[11] = kl_q[1];
  end

  for (genvar m = 0; m < 12; m++) begin : g_mula
    dta_mul #(.WA(DW), .WB(DW)) u_mul (
      .clk_i(clk_i), .en_i(en), .a_i(ma_a[m]), .b_i(ma_b[m]), .p_o(ma_p[m])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= NW'(ma_p[2*i])   - NW'(ma_p[2*i+1]);
        g_q[i] <= NW'(ma_p[6+2*i]) - NW'(ma_p[7+2*i]);
      end
    end
  end

  // ---------------- squared lengths, d.g and g x d
  logic signed [NW-1:0]   mb_a [15];
  logic signed [NW-1:0]   mb_b [15];
  logic signed [2*NW-1:0] mb_p [15];
  logic signed [SW-1:0]   bi_q, bk_q, c_q;
  logic signed [SW-1:0]   t_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mb_a[i]   = d_q[i]; mb_b[i]   = d_q[i];
      mb_a[3+i] = g_q[i]; mb_b[3+i] = g_q[i];
      mb_a[6+i] = d_q[i]; mb_b[6+i] = g_q[i];
    end
    mb_a[9]  = d_q[2]; mb_b[9]  = g_q[1];
    mb_a[10] = d_q[1]; mb_b[10] = g_q[2];
    mb_a[11] = d_q[0]; mb_b[11] = g_q[2];
    mb_a[12] = d_q[2]; mb_b[12] = g_q[0];
    mb_a[13] = d_q[1]; mb_b[13] = g_q[0];
    mb_a[14] = d_q[0]; mb_b[14] = g_q[1];
  end

  for (genvar m = 0; m < 15; m++) begin : g_mulb
    dta_mul #(.WA(NW), .WB(NW)) u_mul (
      .clk_i(clk_i), .en_i(en), .a_i(mb_a[m]), .b_i(mb_b[m]), .p_o(mb_p[m])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bi_q <= SW'(mb_p[0]) + SW'(mb_p[1]) + SW'(mb_p[2]);
      bk_q <= SW'(mb_p[3]) + SW'(mb_p[4]) + SW'(mb_p[5]);
      c_q  <= SW'(mb_p[6]) + SW'(mb_p[7]) + SW'(mb_p[8]);
      for (int i = 0; i < 3; i++) t_q[i] <= SW'(mb_p[9+2*i]) - SW'(mb_p[10+2*i]);
    end
  end

  // ---------------- bi*bk, c*c and the triple product
  logic signed [DW-1:0]    kjd_q [KJ_DLY][3];
  logic signed [SW-1:0]    cd_q [C_DLY];
  logic signed [BW-1:0]    bibk_p, cc_p;
  logic signed [DW+SW-1:0] dd_p [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kjd_q[0] <= kj_q;
      for (int i = 1; i < KJ_DLY; i++) kjd_q[i] <= kjd_q[i-1];
      cd_q[0] <= c_q;
      for (int i = 1; i < C_DLY; i++) cd_q[i] <= cd_q[i-1];
    end
  end

  dta_mul #(.WA(SW), .WB(SW)) u_mul_bibk (
    .clk_i(clk_i), .en_i(en), .a_i(bi_q), .b_i(bk_q), .p_o(bibk_p)
  );

  dta_mul #(.WA(SW), .WB(SW)) u_mul_cc (
    .clk_i(clk_i), .en_i(en), .a_i(c_q), .b_i(c_q), .p_o(cc_p)
  );

  for (genvar m = 0; m < 3; m++) begin : g_muldd
    dta_mul #(.WA(DW), .WB(SW)) u_mul (
      .clk_i(clk_i), .en_i(en), .a_i(kjd_q[KJ_DLY-1][m]), .b_i(t_q[m]), .p_o(dd_p[m])
    );
  end

  // ---------------- difference, magnitudes, sign of the triple product
  logic [BW-1:0]     bibk_f_q, s2_f_q;
  logic [SW-1:0]     cm_f_q;
  logic              cneg_f_q, dneg_f_q;
  logic signed [TW-1:0] dd_sum;

  assign dd_sum = TW'(dd_p[0]) + TW'(dd_p[1]) + TW'(dd_p[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      bibk_f_q <= BW'(bibk_p);
      s2_f_q   <= BW'(bibk_p - cc_p);
      cneg_f_q <= cd_q[C_DLY-1][SW-1];
      cm_f_q   <= cd_q[C_DLY-1][SW-1] ? SW'(-cd_q[C_DLY-1]) : SW'(cd_q[C_DLY-1]);
      dneg_f_q <= dd_sum[TW-1];
    end
  end

  // ---------------- threshold and per-chunk leading one
  logic [NCH*32-1:0] bibk_pad;
  logic [NCH-1:0]    nz_d, nz_q;
  logic [4:0]        pos_d [NCH];
  logic [4:0]        pos_q [NCH];
  logic [BW-1:0]     s2_g_q;
  logic [SW-1:0]     cm_g_q;
  logic              cneg_g_q, degen_g_q;

  assign bibk_pad = (NCH*32)'(bibk_f_q);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      nz_d[c]  = |bibk_pad[32*c +: 32];
      pos_d[c] = '0;
      for (int b = 0; b < 32; b++) begin
        if (bibk_pad[32*c + b]) pos_d[c] = 5'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nz_q      <= nz_d;
      pos_q     <= pos_d;
      s2_g_q    <= s2_f_q;
      cm_g_q    <= cm_f_q;
      cneg_g_q  <= cneg_f_q;
      degen_g_q <= bibk_f_q < DEG_LIM;
    end
  end

  // ---------------- normalizing shift count
  logic [BLW-1:0] bl;
  logic [KW-1:0]  k_d, k_q;
  logic [BW-1:0]  s2_h_q;
  logic [SW-1:0]  cm_h_q;
  logic           cneg_h_q;

  always_comb begin
    bl = '0;
    for (int c = 0; c < NCH; c++) begin
      if (nz_q[c]) bl = BLW'(32 * c + int'(pos_q[c]) + 1);
    end
    if (bl > BLW'(RAD_W)) k_d = KW'((bl - BLW'(RAD_W - 1)) >> 1);
    else                  k_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_q      <= k_d;
      s2_h_q   <= s2_g_q;
      cm_h_q   <= cm_g_q;
      cneg_h_q <= cneg_g_q;
    end
  end

  // ---------------- scaled x and radicand
  logic [SW-1:0]        cm_sh;
  logic [BW-1:0]        s2_sh;
  logic signed [XW-1:0] xpos, x_d, x_q;
  logic [RAD_W-1:0]     rad_q;

  always_comb begin
    cm_sh = cm_h_q >> k_q;
    s2_sh = s2_h_q >> {k_q, 1'b0};
    xpos  = {1'b0, cm_sh[XW-2:0]};
    x_d   = cneg_h_q ? xpos : -xpos;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q   <= x_d;
      rad_q <= s2_sh[RAD_W-1:0];
    end
  end

  // ---------------- square root, CORDIC, and the sidebands that wait for them
  logic signed [XW-1:0] xd_q [X_DLY];
  logic                 dn_q [DN_DLY];
  logic                 dg_q [DG_DLY];
  logic [ROOT_W-1:0]    root;
  logic [ANG_W-1:0]     ang_rad;
  logic [PRW-1:0]       prod_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q[0] <= x_q;
      for (int i = 1; i < X_DLY; i++) xd_q[i] <= xd_q[i-1];
      dn_q[0] <= dneg_f_q;
      for (int i = 1; i < DN_DLY; i++) dn_q[i] <= dn_q[i-1];
      dg_q[0] <= degen_g_q;
      for (int i = 1; i < DG_DLY; i++) dg_q[i] <= dg_q[i-1];
    end
  end

  dta_isqrt #(.W(RAD_W)) u_isqrt (
    .clk_i(clk_i), .en_i(en), .rad_i(rad_q), .root_o(root)
  );

  dta_cordic u_cordic (
    .clk_i(clk_i), .en_i(en), .x_i(xd_q[X_DLY-1]), .y_i(root), .ang_o(ang_rad)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= ang_rad * DEG_PER_RAD_Q24;
    end
  end

  // ---------------- degrees, rounding, sign
  logic [PRW:0] rnd, mag, magc, full, res;

  always_comb begin
    rnd  = (PRW+1)'(prod_q) + ((PRW+1)'(1) << (53 - ANGLE_FRAC_BITS));
    mag  = rnd >> (54 - ANGLE_FRAC_BITS);
    full = (PRW+1)'(180) << ANGLE_FRAC_BITS;
    magc = (mag > full) ? full : mag;
    // a negative half turn folds to +180
    res  = (dn_q[DN_DLY-1] && magc != full) ? -magc : magc;
    if (dg_q[DG_DLY-1]) ang_d = '0;
    else                ang_d = res[ANGLE_W-1:0];
  end

  // ---------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en && vld_q[NST-1]) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NST-1]) begin
      ang_q       <= ang_d;
      degen_out_q <= dg_q[DG_DLY-1];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(ang_q);
  assign m_axis_tuser_o  = degen_out_q;

  // ---------------- assertions
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("degenerate word with nonzero angle");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a blocked output");

  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted word not marked valid in first stage");

endmodule

`default_nettype wire
